// ----- hw/rtl/fixed_point_vertex_transform_perspective_macros.svh -----
// ---------------------------------------------------------------------------
// vertex transform assertion macros
// shared concurrent assertion forms, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH
`define FIXED_POINT_VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent on the same edge
`define VTP_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("vtp assertion failed");
// condition holds on every edge out of reset
`define VTP_ASSERT_ALWAYS(lbl, clk, rstn, a) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a)) \
        else $error("vtp assertion failed");
`else
`define VTP_ASSERT_IMP(lbl, clk, rstn, a, b)
`define VTP_ASSERT_ALWAYS(lbl, clk, rstn, a)
`endif
`endif

// ----- hw/rtl/vtp_pkg.sv -----
// ---------------------------------------------------------------------------
// vertex transform package
// shared types and constants of the vertex transform pipeline
// ---------------------------------------------------------------------------
package vtp_pkg;
    localparam int WORD_W = 32;
    localparam int NUM_REGS = 8;
    localparam int ADDR_W = 6;

    // register indexes
    localparam logic [2:0] REG_EYE_XY = 3'd6;
    localparam logic [2:0] REG_EYE_Z  = 3'd7;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [11:0][WORD_W-1:0] mat_t;

    // sideband that follows an item through the divider
    typedef struct packed {
        word_t pre_x;
        word_t pre_y;
        word_t pre_z;
        logic  persp;
        logic  behind;
        logic  neg_x;
        logic  neg_y;
    } side_t;

    typedef struct packed {
        logic  behind;
        word_t pre_z;
        word_t pre_y;
        word_t pre_x;
        word_t scr_z;
        word_t scr_y;
        word_t scr_x;
    } result_t;
endpackage

// ----- hw/rtl/vtp_xform.sv -----
// ---------------------------------------------------------------------------
// vertex transform matrix stages
// nine products, then per-column sums plus translation
// ---------------------------------------------------------------------------
module vtp_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  vtp_pkg::word_t vx,
    input  vtp_pkg::word_t vy,
    input  vtp_pkg::word_t vz,
    input  vtp_pkg::mat_t  mat,
    output logic           out_valid,
    output vtp_pkg::word_t pre_x,
    output vtp_pkg::word_t pre_y,
    output vtp_pkg::word_t pre_z
);
    import vtp_pkg::*;

    logic signed [2*WORD_W-1:0] prod_reg [9];
    logic                       p_valid_reg;
    word_t                      pre_reg [3];
    logic                       o_valid_reg;
    word_t                      v [3];
    word_t                      sum_next [3];

    assign v[0] = vx;
    assign v[1] = vy;
    assign v[2] = vz;

    // product index row*3+col
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= v[k/3] * $signed(mat[k]);
            end
        end
    end

    always_comb begin
        logic signed [2*WORD_W-1:0] sh;
        for (int j = 0; j < 3; j++) begin
            sum_next[j] = $signed(mat[9+j]);
            for (int i = 0; i < 3; i++) begin
                sh = prod_reg[i*3+j] >>> FRAC_BITS;
                sum_next[j] = sum_next[j] + sh[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                pre_reg[j] <= sum_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign pre_x = pre_reg[0];
    assign pre_y = pre_reg[1];
    assign pre_z = pre_reg[2];
endmodule

// ----- hw/rtl/vtp_persp.sv -----
// ---------------------------------------------------------------------------
// vertex transform perspective setup
// eye products and depth, then numerators, magnitudes and signs
// ---------------------------------------------------------------------------
module vtp_persp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  vtp_pkg::word_t        pre_x,
    input  vtp_pkg::word_t        pre_y,
    input  vtp_pkg::word_t        pre_z,
    input  vtp_pkg::word_t        eye_x,
    input  vtp_pkg::word_t        eye_y,
    input  vtp_pkg::word_t        eye_z,
    output logic                  out_valid,
    output vtp_pkg::side_t        side,
    output logic [vtp_pkg::WORD_W-1:0] mag_x,
    output logic [vtp_pkg::WORD_W-1:0] mag_y,
    output logic [vtp_pkg::WORD_W-1:0] mag_d
);
    import vtp_pkg::*;

    localparam int DSHIFT = FRAC_BITS - 2;
    localparam int PSHIFT = 2 * FRAC_BITS - 2;

    logic signed [2*WORD_W-1:0] pxz_reg, exz_reg, pyz_reg, eyz_reg;
    word_t pre_x_reg, pre_y_reg, pre_z_reg, denom_reg;
    logic  persp_reg, valid_a_reg;

    side_t side_reg;
    logic [WORD_W-1:0] mag_x_reg, mag_y_reg, mag_d_reg;
    logic  valid_b_reg;

    word_t diff;
    word_t num_x, num_y;
    logic signed [2*WORD_W-1:0] s0, s1, s2, s3;

    assign diff = eye_z - pre_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxz_reg   <= pre_x * eye_z;
            exz_reg   <= eye_x * pre_z;
            pyz_reg   <= pre_y * eye_z;
            eyz_reg   <= eye_y * pre_z;
            denom_reg <= diff >>> DSHIFT;
            pre_x_reg <= pre_x;
            pre_y_reg <= pre_y;
            pre_z_reg <= pre_z;
            persp_reg <= (eye_z != '0);
        end
    end

    always_comb begin
        s0 = pxz_reg >>> PSHIFT;
        s1 = exz_reg >>> PSHIFT;
        s2 = pyz_reg >>> PSHIFT;
        s3 = eyz_reg >>> PSHIFT;
        num_x = s0[WORD_W-1:0] - s1[WORD_W-1:0];
        num_y = s2[WORD_W-1:0] - s3[WORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg.pre_x  <= pre_x_reg;
            side_reg.pre_y  <= pre_y_reg;
            side_reg.pre_z  <= pre_z_reg;
            side_reg.persp  <= persp_reg;
            side_reg.behind <= persp_reg && !denom_reg[WORD_W-1];
            side_reg.neg_x  <= num_x[WORD_W-1] ^ denom_reg[WORD_W-1];
            side_reg.neg_y  <= num_y[WORD_W-1] ^ denom_reg[WORD_W-1];
            mag_x_reg <= num_x[WORD_W-1] ? WORD_W'(-num_x) : num_x;
            mag_y_reg <= num_y[WORD_W-1] ? WORD_W'(-num_y) : num_y;
            mag_d_reg <= denom_reg[WORD_W-1] ? WORD_W'(-denom_reg) : denom_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign side  = side_reg;
    assign mag_x = mag_x_reg;
    assign mag_y = mag_y_reg;
    assign mag_d = mag_d_reg;
endmodule

// ----- hw/rtl/vtp_div.sv -----
// ---------------------------------------------------------------------------
// vertex transform divider
// two-lane unsigned restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
module vtp_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  vtp_pkg::side_t             in_side,
    input  logic [vtp_pkg::WORD_W-1:0] num_x,
    input  logic [vtp_pkg::WORD_W-1:0] num_y,
    input  logic [vtp_pkg::WORD_W-1:0] den,
    output logic                       out_valid,
    output vtp_pkg::side_t             out_side,
    output logic [vtp_pkg::WORD_W-1:0] quo_x,
    output logic [vtp_pkg::WORD_W-1:0] quo_y
);
    import vtp_pkg::*;

    localparam int N = WORD_W;

    // index 0 is the input, index N the last stage
    logic [N-1:0] n_reg   [N+1][2];
    logic [N-1:0] rem_reg [N+1][2];
    logic [N-1:0] den_reg [N+1];
    side_t        side_reg [N+1];
    logic         valid_reg [N+1];

    assign n_reg[0][0]   = num_x;
    assign n_reg[0][1]   = num_y;
    assign rem_reg[0][0] = '0;
    assign rem_reg[0][1] = '0;
    assign den_reg[0]    = den;
    assign side_reg[0]   = in_side;
    assign valid_reg[0]  = in_valid;

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [N:0]   trial [2];
        logic [N:0]   diff  [2];
        logic [N-1:0] rem_next [2];
        logic [N-1:0] n_next [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                trial[l] = {rem_reg[s][l], n_reg[s][l][N-1]};
                diff[l]  = trial[l] - {1'b0, den_reg[s]};
                if (!diff[l][N]) begin
                    rem_next[l] = diff[l][N-1:0];
                    n_next[l]   = {n_reg[s][l][N-2:0], 1'b1};
                end else begin
                    rem_next[l] = trial[l][N-1:0];
                    n_next[l]   = {n_reg[s][l][N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[s+1]    <= n_next;
                rem_reg[s+1]  <= rem_next;
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (en) begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_side  = side_reg[N];
    assign quo_x     = n_reg[N][0];
    assign quo_y     = n_reg[N][1];
endmodule

// ----- hw/rtl/fixed_point_vertex_transform_perspective.sv -----
// ---------------------------------------------------------------------------
// fixed-point vertex transform with perspective divide
// affine 4x3 matrix transform of a 16.16 vertex, then optional projection
// ---------------------------------------------------------------------------
//  channel | direction | contents
//  s_axis  | in        | tdata: vert_x, vert_y, vert_z
//  m_axis  | out       | tdata: screen_x/y/z, pre_x/y/z; tuser: behind_eye
//  apb     | in/out    | 64-bit registers at byte address 8*i
//
//  one vertex per cycle while the fifo has room; each result passes the transform,
//  perspective and quotient stages before it is written to the result fifo
//  the quotient pipeline has 32 stages, one bit per stage
//  aresetn is synchronous, active low; clears valid bits, fifo pointers and config registers
//  a two-entry result fifo keeps input open while one result waits
//  the whole pipeline freezes only when both fifo entries are occupied
// ---------------------------------------------------------------------------
`include "fixed_point_vertex_transform_perspective_macros.svh"

module fixed_point_vertex_transform_perspective #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // vertex requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,   // vert_x, vert_y, vert_z
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [191:0]                m_tdata,   // screen_x/y/z, pre_x/y/z
    output logic                        m_tuser,   // behind_eye
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vtp_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import vtp_pkg::*;

    // configuration registers
    logic [63:0] cfg_reg [NUM_REGS];
    logic [2:0]  cfg_idx;
    mat_t        mat;
    word_t       eye_x, eye_y, eye_z;

    // pipeline control
    logic        en;
    logic        xf_valid, ps_valid, dv_valid;
    word_t       pre_x, pre_y, pre_z;
    side_t       ps_side, dv_side;
    logic [WORD_W-1:0] mag_x, mag_y, mag_d, quo_x, quo_y;

    // result fifo
    result_t     fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;
    result_t     res_next;
    word_t       qx, qy, sx, sy;

    assign cfg_idx = paddr[ADDR_W-1:3];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            if (cfg_idx == REG_EYE_Z) begin
                cfg_reg[cfg_idx] <= {32'd0, pwdata[31:0]};
            end else begin
                cfg_reg[cfg_idx] <= pwdata;
            end
        end
    end

    assign prdata = cfg_reg[cfg_idx];

    // matrix word k sits in pair k/2, upper half when k is odd
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            mat[k] = (k % 2 == 1) ? cfg_reg[k/2][63:32] : cfg_reg[k/2][31:0];
        end
    end

    assign eye_x = cfg_reg[REG_EYE_XY][31:0];
    assign eye_y = cfg_reg[REG_EYE_XY][63:32];
    assign eye_z = cfg_reg[REG_EYE_Z][31:0];

    // advance everywhere unless the fifo is full
    assign en       = (count_reg != 2'd2);
    assign s_tready = en;

    vtp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .vx        (s_tdata[31:0]),
        .vy        (s_tdata[63:32]),
        .vz        (s_tdata[95:64]),
        .mat       (mat),
        .out_valid (xf_valid),
        .pre_x     (pre_x),
        .pre_y     (pre_y),
        .pre_z     (pre_z)
    );

    vtp_persp #(.FRAC_BITS(FRAC_BITS)) u_persp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (xf_valid),
        .pre_x     (pre_x),
        .pre_y     (pre_y),
        .pre_z     (pre_z),
        .eye_x     (eye_x),
        .eye_y     (eye_y),
        .eye_z     (eye_z),
        .out_valid (ps_valid),
        .side      (ps_side),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .mag_d     (mag_d)
    );

    vtp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ps_valid),
        .in_side   (ps_side),
        .num_x     (mag_x),
        .num_y     (mag_y),
        .den       (mag_d),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo_x     (quo_x),
        .quo_y     (quo_y)
    );

    // restore quotient sign, scale back to fixed point and select the screen outputs
    always_comb begin
        qx = dv_side.neg_x ? WORD_W'(-quo_x) : quo_x;
        qy = dv_side.neg_y ? WORD_W'(-quo_y) : quo_y;
        sx = qx << FRAC_BITS;
        sy = qy << FRAC_BITS;
        res_next.pre_x  = dv_side.pre_x;
        res_next.pre_y  = dv_side.pre_y;
        res_next.pre_z  = dv_side.pre_z;
        res_next.behind = dv_side.behind;
        if (!dv_side.persp) begin
            res_next.scr_x = dv_side.pre_x;
            res_next.scr_y = dv_side.pre_y;
            res_next.scr_z = dv_side.pre_z;
        end else if (dv_side.behind) begin
            res_next.scr_x = '1;
            res_next.scr_y = '1;
            res_next.scr_z = '1;
        end else begin
            res_next.scr_x = sx;
            res_next.scr_y = sy;
            res_next.scr_z = dv_side.pre_z;
        end
    end

    assign push = en && dv_valid;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {fifo_reg[rd_ptr_reg].pre_z, fifo_reg[rd_ptr_reg].pre_y,
                       fifo_reg[rd_ptr_reg].pre_x, fifo_reg[rd_ptr_reg].scr_z,
                       fifo_reg[rd_ptr_reg].scr_y, fifo_reg[rd_ptr_reg].scr_x};
    assign m_tuser  = fifo_reg[rd_ptr_reg].behind;

    `VTP_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg != 2'd3)
    `VTP_ASSERT_IMP(a_behind_ones, aclk, aresetn, m_tvalid && m_tuser, m_tdata[95:0] == '1)
    `VTP_ASSERT_IMP(a_behind_persp, aclk, aresetn, m_tvalid && m_tuser, eye_z != '0)
endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// vertex transform testbench
// streams 16.16 vertices through the affine transform and perspective
// divide under several matrix and eye settings, checking every result
// against an in-bench predictor while both stream sides idle at random
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vtp_pkg::*;

    localparam int FRAC = 16;
    localparam int DSHIFT = FRAC - 2;
    localparam int PSHIFT = 2 * FRAC - 2;
    localparam int LATENCY = 38;
    localparam int RANDOM_ITEMS = 550;

    // register indexes (pairs of the matrix, then eye)
    localparam logic [2:0] REG_PAIR0 = 3'd0;
    localparam logic [2:0] REG_PAIR5 = 3'd5;

    typedef struct packed {
        logic  behind;
        word_t pre_z;
        word_t pre_y;
        word_t pre_x;
        word_t scr_z;
        word_t scr_y;
        word_t scr_x;
    } vtx_result_t;

    typedef struct {
        word_t vx;
        word_t vy;
        word_t vz;
        bit    typed;     // expected result typed in the row
        word_t sx;
        word_t sy;
        word_t sz;
        bit    bh;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;     // vert_x, vert_y, vert_z
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;     // screen_x/y/z, pre_x/y/z
    logic         m_tuser;     // behind_eye
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    fixed_point_vertex_transform_perspective #(.FRAC_BITS(FRAC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the configuration
    logic [63:0] cfg_shadow [0:7];
    vtx_result_t pending_results[$];
    int fail_count = 0;
    int checked = 0;
    int behind_seen = 0;
    bit stall_mode;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    // signed product shifted arithmetically, wrapped to 32 bits
    function automatic word_t fx_mul(word_t a, word_t b, int sh);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return word_t'(p >>> sh);
    endfunction

    function automatic word_t mat_entry(int k);
        logic [63:0] r;
        r = cfg_shadow[k / 2];
        return (k % 2) ? word_t'(r[63:32]) : word_t'(r[31:0]);
    endfunction

    function automatic vtx_result_t project_vertex(word_t vx, word_t vy, word_t vz);
        vtx_result_t r;
        word_t v [3];
        word_t pre [3];
        word_t eye [2];
        word_t ez, acc, num;
        logic signed [31:0] denom, quo;
        v[0] = vx; v[1] = vy; v[2] = vz;
        for (int j = 0; j < 3; j++) begin
            acc = '0;
            for (int i = 0; i < 3; i++)
                acc = acc + fx_mul(v[i], mat_entry(i * 3 + j), FRAC);
            pre[j] = acc + mat_entry(9 + j);
        end
        eye[0] = word_t'(cfg_shadow[REG_EYE_XY][31:0]);
        eye[1] = word_t'(cfg_shadow[REG_EYE_XY][63:32]);
        ez = word_t'(cfg_shadow[REG_EYE_Z][31:0]);
        r.pre_x = pre[0]; r.pre_y = pre[1]; r.pre_z = pre[2];
        r.scr_x = pre[0]; r.scr_y = pre[1]; r.scr_z = pre[2];
        r.behind = 1'b0;
        if (ez != 0) begin
            denom = word_t'(ez - pre[2]) >>> DSHIFT;
            if (denom >= 0) begin
                r.scr_x = -1; r.scr_y = -1; r.scr_z = -1;
                r.behind = 1'b1;
            end else begin
                for (int i = 0; i < 2; i++) begin
                    num = fx_mul(pre[i], ez, PSHIFT) - fx_mul(eye[i], pre[2], PSHIFT);
                    // the one overflowing quotient wraps to itself
                    if (num == 32'sh8000_0000 && denom == -1)
                        quo = num;
                    else
                        quo = num / denom;
                    if (i == 0) r.scr_x = quo << FRAC;
                    else r.scr_y = quo << FRAC;
                end
            end
        end
        return r;
    endfunction

    // apb write: setup then access, pready always high
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = ADDR_W'(idx) << 3; pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cfg_shadow[idx] = (idx == REG_EYE_Z) ? {32'h0, val[31:0]} : val;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // burst sender: vertex held until the request is taken
    int burst_left = 0;
    task automatic send_vertex(word_t vx, word_t vy, word_t vz);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tdata = {vz, vy, vx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(project_vertex(vx, vy, vz));
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid = 1'b0;
        burst_left = 0;
    endtask

    // receiver stall pattern, sometimes never stalling
    int stall_phase = 0;
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (!aresetn || !stall_mode)
            m_tready <= 1'b1;
        else
            m_tready <= (stall_phase % 7 < 4) ? ($urandom_range(0, 3) != 0) : 1'b0;
    end

    // result checker
    always @(posedge aclk) begin
        vtx_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (got.behind) behind_seen++;
                if (got.scr_x !== want.scr_x) begin
                    $error("screen_x exp %h got %h", want.scr_x, got.scr_x); fail_count++;
                end
                if (got.scr_y !== want.scr_y) begin
                    $error("screen_y exp %h got %h", want.scr_y, got.scr_y); fail_count++;
                end
                if (got.scr_z !== want.scr_z) begin
                    $error("screen_z exp %h got %h", want.scr_z, got.scr_z); fail_count++;
                end
                if (got.pre_x !== want.pre_x) begin
                    $error("pre_x exp %h got %h", want.pre_x, got.pre_x); fail_count++;
                end
                if (got.pre_y !== want.pre_y) begin
                    $error("pre_y exp %h got %h", want.pre_y, got.pre_y); fail_count++;
                end
                if (got.pre_z !== want.pre_z) begin
                    $error("pre_z exp %h got %h", want.pre_z, got.pre_z); fail_count++;
                end
                if (got.behind !== want.behind) begin
                    $error("behind_eye exp %b got %b", want.behind, got.behind);
                    fail_count++;
                end
            end
        end
    end

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return word_t'($urandom());
        endcase
    endfunction

    // small matrix entry, mostly within two units
    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endfunction

    task automatic random_matrix(bit persp);
        for (int i = REG_PAIR0; i <= REG_PAIR5; i++)
            reg_write(3'(i), {rand_coef(), rand_coef()});
        reg_write(REG_EYE_XY, {rand_coef(), rand_coef()});
        // eye in front of most points so projection is usually taken
        reg_write(REG_EYE_Z, persp ? {32'h0, 32'($urandom_range(1, 32'h0040_0000))
                                      - 32'h0020_0000} : 64'h0);
    endtask

    stim_row_t directed [$];

    initial begin
        stim_row_t row;
        vtx_result_t want;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_mode = 1'b0;
        for (int i = 0; i < 8; i++) cfg_shadow[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // after reset every matrix entry is zero: all outputs zero
        directed.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 1, 0, 0, 0, 0});
        directed.push_back('{32'sh8000_0000, 32'sh7fff_ffff, -1, 1, 0, 0, 0, 0});
        directed.push_back('{0, 0, 0, 1, 0, 0, 0, 0});
        foreach (directed[i]) begin
            row = directed[i];
            want = project_vertex(row.vx, row.vy, row.vz);
            if (row.typed && {want.scr_x, want.scr_y, want.scr_z, want.behind}
                    !== {row.sx, row.sy, row.sz, row.bh}) begin
                $error("directed row %0d disagrees with predictor", i);
                fail_count++;
            end
            send_vertex(row.vx, row.vy, row.vz);
        end
        end_burst();
        drain_results();

        // identity matrix with translation, eye at z=+4: behind and in front
        reg_write(REG_PAIR0, {32'h0, 32'h0001_0000});
        reg_write(3'd1, 64'h0);
        reg_write(3'd2, {32'h0, 32'h0001_0000});
        reg_write(3'd3, 64'h0);
        reg_write(3'd4, {32'h0001_0000, 32'h0001_0000});
        reg_write(REG_PAIR5, {32'hffff_0000, 32'h0000_8000});
        reg_write(REG_EYE_XY, {32'h0002_0000, 32'hfffe_0000});
        reg_write(REG_EYE_Z, 64'hdead_beef_0004_0000);
        directed.delete();
        // pre_z equal to eye: denominator zero, behind
        directed.push_back('{0, 0, 32'sh0005_0000, 1, -1, -1, -1, 1});
        // far below the eye: behind
        directed.push_back('{32'sh7fff_ffff, 32'sh8000_0000, -32'sh4000_0000, 1, -1, -1, -1, 1});
        directed.push_back('{32'sh0001_0000, 32'sh0002_0000, -32'sh0004_0000, 0, 0, 0, 0, 0});
        directed.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 0});
        directed.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh0004_ffff, 0, 0, 0, 0, 0});
        directed.push_back('{-1, -1, -1, 0, 0, 0, 0, 0});
        directed.push_back('{32'sh1234_5678, -32'sh0765_4321, 32'sh0003_0000, 0, 0, 0, 0, 0});
        foreach (directed[i]) begin
            row = directed[i];
            want = project_vertex(row.vx, row.vy, row.vz);
            if (row.typed && {want.scr_x, want.scr_y, want.scr_z, want.behind}
                    !== {row.sx, row.sy, row.sz, row.bh}) begin
                $error("directed row %0d disagrees with predictor", i);
                fail_count++;
            end
            send_vertex(row.vx, row.vy, row.vz);
        end
        end_burst();
        drain_results();

        // extreme matrix, negative eye, full-scale coefficients
        for (int i = REG_PAIR0; i <= REG_PAIR5; i++)
            reg_write(3'(i), {32'h8000_0000, 32'h7fff_ffff});
        reg_write(REG_EYE_XY, 64'hffff_ffff_ffff_ffff);
        reg_write(REG_EYE_Z, 64'h0000_0000_8000_0000);
        for (int i = 0; i < 8; i++)
            send_vertex(rand_word(), rand_word(), rand_word());
        end_burst();
        drain_results();

        // random phases, perspective off in every fourth phase
        stall_mode = 1'b1;
        for (int ph = 0; ph < 11; ph++) begin
            random_matrix(ph % 4 != 3);
            if (ph == 5) stall_mode = 1'b0;
            if (ph == 6) stall_mode = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / 11; n++)
                send_vertex(rand_word(), rand_word(), rand_word());
            end_burst();
            drain_results();
        end

        $display("checked %0d vertex results over directed and random matrices,", checked);
        $display("%0d of them behind the eye, with stalls on both stream sides", behind_seen);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_xform.sv
hw/rtl/vtp_persp.sv
hw/rtl/vtp_div.sv
hw/rtl/fixed_point_vertex_transform_perspective.sv
tb/testbench.sv
